FILE: src/cba_pkg.sv
package cba_pkg;

	localparam int BLOCKS = 64;
	localparam int IDX_W = $clog2(BLOCKS);
	localparam int LEN_W = $clog2(BLOCKS + 1);
	localparam int RUN_MAX = 127;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_SET = 1'b1;

	localparam logic [1:0] MODE_BEST = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FAIL = 2'd1;
	localparam logic [1:0] STAT_SET = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MARK
	} state_t;

	function automatic logic [6:0] sat_run(input logic [LEN_W-1:0] n);
		if (32'(n) > 32'(RUN_MAX)) begin
			return 7'(RUN_MAX);
		end
		return 7'(n);
	endfunction

endpackage

FILE: src/cba_ram.sv
module cba_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/contiguous_block_allocator_top.sv
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// request   | start, busy (accept when   | opcode, block_count, block_index, block_used
//           | start & !busy)             |
// result    | done (one-cycle strobe)    | status, start_block, run_length
// config    | cfg_valid, cfg_ready       | fit_mode
//
// a set item: the map bit is written at accept, done follows next cycle
// an allocate item scans the map (one map read a cycle through the single read port,
// then a wait for the last read to land), decides, then marks one block a cycle;
// done follows next; if nothing fits, done follows the decision without marking
// after reset a clearing pass writes every map entry free, with busy high
// the receiver cannot stall: each result is shown for exactly one cycle
module contiguous_block_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       opcode,
	input  logic [6:0] block_count,
	input  logic [5:0] block_index,
	input  logic       block_used,
	output logic       done,
	output logic [1:0] status,
	output logic [5:0] start_block,
	output logic [6:0] run_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] fit_mode
);

	localparam int IW = cba_pkg::IDX_W;
	localparam int LW = cba_pkg::LEN_W;
	localparam logic [IW-1:0] LAST = IW'(cba_pkg::BLOCKS - 1);

	cba_pkg::state_t state_q, state_d;

	logic [1:0]    mode_q;
	logic [6:0]    count_q;
	logic [IW-1:0] clr_addr_q;
	logic [IW-1:0] rd_addr_q;
	logic          rd_on_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] run_start_q;
	logic [LW-1:0] run_len_q;
	logic [IW-1:0] big_start_q;
	logic [LW-1:0] big_len_q;
	logic          first_ok_q;
	logic [IW-1:0] first_start_q;
	logic          best_ok_q;
	logic [IW-1:0] best_start_q;
	logic [LW-1:0] best_len_q;
	logic [IW-1:0] mark_addr_q;
	logic [IW-1:0] alloc_start_q;
	logic [6:0]    mark_cnt_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [5:0]    start_block_q;
	logic [6:0]    run_length_q;

	logic          accept;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_re;
	logic          ram_rdata;

	logic          free_s1;
	logic          last_s1;
	logic [LW-1:0] ext_len;
	logic [IW-1:0] cl_start;
	logic [LW-1:0] cl_len;
	logic          cl_valid;
	logic          cl_fits;

	logic          dec_ok;
	logic [IW-1:0] dec_start;

	assign busy = (state_q != cba_pkg::S_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign status = status_q;
	assign start_block = start_block_q;
	assign run_length = run_length_q;

	cba_ram #(
		.DEPTH(cba_pkg::BLOCKS),
		.WIDTH(1)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// run tracking on the bit that came back from the map
	assign free_s1 = !ram_rdata;
	assign last_s1 = (idx_s1 == LAST);
	assign ext_len = run_len_q + LW'(1);
	assign cl_start = (run_len_q == '0) ? idx_s1 : run_start_q;
	assign cl_len = free_s1 ? ext_len : run_len_q;
	// a run closes at a used block, or at the end of the map
	assign cl_valid = valid_s1 && (!free_s1 || last_s1);
	assign cl_fits = (count_q != '0) && (32'(cl_len) >= 32'(count_q));

	always_comb begin
		case (mode_q)
			cba_pkg::MODE_BEST: begin
				dec_ok = best_ok_q;
				dec_start = best_start_q;
			end
			cba_pkg::MODE_WORST: begin
				dec_ok = (count_q != '0) && (32'(big_len_q) >= 32'(count_q));
				// centered in the largest run, rounded down
				dec_start = IW'(LW'(big_start_q) + ((big_len_q - LW'(count_q)) >> 1));
			end
			default: begin
				dec_ok = first_ok_q;
				dec_start = first_start_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = mark_addr_q;
		ram_wdata = 1'b1;
		ram_re = 1'b0;
		case (state_q)
			cba_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = 1'b0;
				if (clr_addr_q == LAST) begin
					state_d = cba_pkg::S_IDLE;
				end
			end
			cba_pkg::S_IDLE: begin
				if (accept) begin
					if (opcode == cba_pkg::OP_SET) begin
						ram_we = (32'(block_index) < 32'(cba_pkg::BLOCKS));
						ram_waddr = IW'(block_index);
						ram_wdata = block_used;
					end else begin
						state_d = cba_pkg::S_SCAN;
					end
				end
			end
			cba_pkg::S_SCAN: begin
				ram_re = rd_on_q;
				if (valid_s1 && last_s1) begin
					state_d = cba_pkg::S_DECIDE;
				end
			end
			cba_pkg::S_DECIDE: begin
				state_d = dec_ok ? cba_pkg::S_MARK : cba_pkg::S_IDLE;
			end
			cba_pkg::S_MARK: begin
				ram_we = 1'b1;
				if (mark_cnt_q == 7'd1) begin
					state_d = cba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_CLEAR;
			mode_q <= cba_pkg::MODE_FIRST;
			clr_addr_q <= '0;
			rd_on_q <= 1'b0;
			valid_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				mode_q <= fit_mode;
			end
			if (state_q == cba_pkg::S_CLEAR) begin
				clr_addr_q <= clr_addr_q + IW'(1);
			end
			valid_s1 <= (state_q == cba_pkg::S_SCAN) && rd_on_q;
			if (accept && opcode == cba_pkg::OP_ALLOC) begin
				rd_on_q <= 1'b1;
			end else if (state_q == cba_pkg::S_SCAN && rd_addr_q == LAST) begin
				rd_on_q <= 1'b0;
			end
			if (accept && opcode == cba_pkg::OP_SET) begin
				done_q <= 1'b1;
			end
			if (state_q == cba_pkg::S_DECIDE && !dec_ok) begin
				done_q <= 1'b1;
			end
			if (state_q == cba_pkg::S_MARK && mark_cnt_q == 7'd1) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= block_count;
			rd_addr_q <= '0;
			run_start_q <= '0;
			run_len_q <= '0;
			big_start_q <= '0;
			big_len_q <= '0;
			first_ok_q <= 1'b0;
			first_start_q <= '0;
			best_ok_q <= 1'b0;
			best_start_q <= '0;
			best_len_q <= '0;
			if (opcode == cba_pkg::OP_SET) begin
				status_q <= cba_pkg::STAT_SET;
				start_block_q <= block_index;
				run_length_q <= '0;
			end
		end
		if (state_q == cba_pkg::S_SCAN && rd_on_q) begin
			idx_s1 <= rd_addr_q;
			rd_addr_q <= rd_addr_q + IW'(1);
		end
		if (state_q == cba_pkg::S_SCAN && valid_s1) begin
			if (free_s1) begin
				if (run_len_q == '0) begin
					run_start_q <= idx_s1;
				end
				run_len_q <= ext_len;
			end
			if (cl_valid) begin
				run_len_q <= '0;
				if (cl_len > big_len_q) begin
					big_len_q <= cl_len;
					big_start_q <= cl_start;
				end
				if (cl_fits) begin
					if (!first_ok_q) begin
						first_ok_q <= 1'b1;
						first_start_q <= cl_start;
					end
					if (!best_ok_q || cl_len < best_len_q) begin
						best_ok_q <= 1'b1;
						best_start_q <= cl_start;
						best_len_q <= cl_len;
					end
				end
			end
		end
		if (state_q == cba_pkg::S_DECIDE) begin
			mark_addr_q <= dec_start;
			alloc_start_q <= dec_start;
			mark_cnt_q <= count_q;
			if (!dec_ok) begin
				status_q <= cba_pkg::STAT_FAIL;
				start_block_q <= 6'(big_start_q);
				run_length_q <= cba_pkg::sat_run(big_len_q);
			end
		end
		if (state_q == cba_pkg::S_MARK) begin
			mark_addr_q <= mark_addr_q + IW'(1);
			mark_cnt_q <= mark_cnt_q - 7'd1;
			if (mark_cnt_q == 7'd1) begin
				status_q <= cba_pkg::STAT_OK;
				start_block_q <= 6'(alloc_start_q);
				run_length_q <= count_q;
			end
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 2 * cba_pkg::BLOCKS + 16;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 62;
	localparam int SCRIPT_ROWS = 28;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] first_blk;
		logic [6:0] blk_count;
	} outcome_t;

	typedef struct packed {
		bit is_cfg;
		logic [1:0] mode;
		logic op;
		logic [6:0] cnt;
		logic [5:0] idx;
		logic used;
		bit typed;
		outcome_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = cba_pkg::OP_ALLOC;
	logic [6:0] block_count = '0;
	logic [5:0] block_index = '0;
	logic block_used = 1'b0;
	logic done;
	logic [1:0] status;
	logic [5:0] start_block;
	logic [6:0] run_length;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] fit_mode = cba_pkg::MODE_FIRST;

	// model of the allocator state
	bit [cba_pkg::BLOCKS-1:0] occ_map = '0;
	logic [1:0] fit_sel = cba_pkg::MODE_FIRST;

	outcome_t due_results[$];
	int mismatches = 0;
	int quiet = 0;
	int idle_pct = 0;
	script_row_t script [SCRIPT_ROWS];

	contiguous_block_allocator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.block_count(block_count),
		.block_index(block_index),
		.block_used(block_used),
		.done(done),
		.status(status),
		.start_block(start_block),
		.run_length(run_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.fit_mode(fit_mode)
	);

	always #4 clk = ~clk;

	// write the map bit for a set; for an allocate, scan the map for free runs, place the request and mark it
	task automatic place_request(input logic op, input logic [6:0] cnt, input logic [5:0] idx,
			input logic used, output outcome_t res);
		int run_s, run_l, big_s, big_l, first_s, best_s, best_l, pos;
		bit first_ok, best_ok, ok, is_free;
		run_s = 0;
		run_l = 0;
		big_s = 0;
		big_l = 0;
		first_s = 0;
		best_s = 0;
		best_l = 0;
		pos = 0;
		first_ok = 1'b0;
		best_ok = 1'b0;
		ok = 1'b0;
		if (op == cba_pkg::OP_SET) begin
			occ_map[idx] = used;
			res = '{cba_pkg::STAT_SET, idx, 7'd0};
		end else begin
			// one step past the end closes a trailing free run
			for (int i = 0; i <= cba_pkg::BLOCKS; i++) begin
				is_free = (i < cba_pkg::BLOCKS) ? !occ_map[i] : 1'b0;
				if (is_free) begin
					if (run_l == 0)
						run_s = i;
					run_l++;
				end else begin
					if (run_l > 0) begin
						if (run_l > big_l) begin
							big_l = run_l;
							big_s = run_s;
						end
						if (cnt != 0 && run_l >= int'(cnt)) begin
							if (!first_ok) begin
								first_ok = 1'b1;
								first_s = run_s;
							end
							if (!best_ok || run_l < best_l) begin
								best_ok = 1'b1;
								best_s = run_s;
								best_l = run_l;
							end
						end
					end
					run_l = 0;
				end
			end
			case (fit_sel)
				cba_pkg::MODE_BEST: begin
					ok = best_ok;
					pos = best_s;
				end
				cba_pkg::MODE_WORST: begin
					ok = (cnt != 0) && (big_l >= int'(cnt));
					pos = ok ? big_s + (big_l - int'(cnt)) / 2 : 0;
				end
				default: begin
					ok = first_ok;
					pos = first_s;
				end
			endcase
			if (!ok) begin
				res = '{cba_pkg::STAT_FAIL, 6'(big_s), 7'(big_l)};
			end else begin
				for (int k = 0; k < int'(cnt); k++)
					if (pos + k < cba_pkg::BLOCKS)
						occ_map[pos + k] = 1'b1;
				res = '{cba_pkg::STAT_OK, 6'(pos), cnt};
			end
		end
	endtask

	// called right after a rising edge; returns at the edge that accepts the item
	task automatic send_item(input logic op, input logic [6:0] cnt, input logic [5:0] idx,
			input logic used, input bit typed, input outcome_t want);
		outcome_t predicted;
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 11);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		block_count <= cnt;
		block_index <= idx;
		block_used <= used;
		do @(posedge clk); while (busy);
		place_request(op, cnt, idx, used, predicted);
		due_results.push_back(typed ? want : predicted);
	endtask

	task automatic write_mode(input logic [1:0] m);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		fit_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fit_sel = m;
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$error("result with no item outstanding: status %0d start_block %0d run_length %0d",
					status, start_block, run_length);
				mismatches++;
			end else begin
				w = due_results.pop_front();
				if (status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, status);
					mismatches++;
				end
				if (start_block !== w.first_blk) begin
					$error("start_block: expected %0d, got %0d", w.first_blk, start_block);
					mismatches++;
				end
				if (run_length !== w.blk_count) begin
					$error("run_length: expected %0d, got %0d", w.blk_count, run_length);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int sent, pick, base, span;
		logic [6:0] cnt;
		logic [1:0] m;
		outcome_t none;
		none = '{cba_pkg::STAT_OK, 6'd0, 7'd0};

		// map starts empty, mode starts at first fit
		script = '{
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd0, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_FAIL, 6'd0, 7'd64}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd127, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_FAIL, 6'd0, 7'd64}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd65, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_FAIL, 6'd0, 7'd64}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd64, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_OK, 6'd0, 7'd64}},
			// map full: nothing free at all
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd1, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_FAIL, 6'd0, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd63, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd63, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd0, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd1, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_OK, 6'd0, 7'd1}},
			// only a trailing run is left
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd1, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_OK, 6'd63, 7'd1}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd10, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd10, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd11, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd11, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd12, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd12, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd30, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd30, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd31, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd31, 7'd0}},
			// first fit picks the lower, longer run
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd2, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_OK, 6'd10, 7'd2}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_ALLOC, 7'd3, 6'd0, 1'b0, 1'b1,
				'{cba_pkg::STAT_FAIL, 6'd30, 7'd2}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd42, 1'b1, 1'b1,
				'{cba_pkg::STAT_SET, 6'd42, 7'd0}},
			'{1'b0, cba_pkg::MODE_FIRST, cba_pkg::OP_SET, 7'd0, 6'd21, 1'b0, 1'b1,
				'{cba_pkg::STAT_SET, 6'd21, 7'd0}},
			'{1'b1, cba_pkg::MODE_BEST, cba_pkg::OP_ALLOC, 7'd0, 6'd0, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_BEST, cba_pkg::OP_SET, 7'd0, 6'd5, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_BEST, cba_pkg::OP_SET, 7'd0, 6'd6, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_BEST, cba_pkg::OP_SET, 7'd0, 6'd7, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_BEST, cba_pkg::OP_ALLOC, 7'd2, 6'd0, 1'b0, 1'b0, none},
			'{1'b1, cba_pkg::MODE_WORST, cba_pkg::OP_ALLOC, 7'd0, 6'd0, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_WORST, cba_pkg::OP_ALLOC, 7'd1, 6'd0, 1'b0, 1'b0, none},
			'{1'b0, cba_pkg::MODE_WORST, cba_pkg::OP_ALLOC, 7'd0, 6'd0, 1'b0, 1'b0, none},
			'{1'b1, MODE_SPARE, cba_pkg::OP_ALLOC, 7'd0, 6'd0, 1'b0, 1'b0, none},
			'{1'b0, MODE_SPARE, cba_pkg::OP_ALLOC, 7'd1, 6'd0, 1'b0, 1'b0, none}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 25;
		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (script[r].is_cfg)
				write_mode(script[r].mode);
			else
				send_item(script[r].op, script[r].cnt, script[r].idx, script[r].used,
					script[r].typed, script[r].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: m = cba_pkg::MODE_WORST;
				1: m = cba_pkg::MODE_BEST;
				2: m = MODE_SPARE;
				3: m = cba_pkg::MODE_FIRST;
				default: m = 2'($urandom_range(0, 3));
			endcase
			write_mode(m);
			// last phases run back to back
			if (ph >= PHASES - 2)
				idle_pct = 0;
			else
				idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 35;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					pick = $urandom_range(0, 99);
					if (pick < 5)
						cnt = 7'd0;
					else if (pick < 75)
						cnt = 7'($urandom_range(1, 8));
					else if (pick < 90)
						cnt = 7'($urandom_range(9, 32));
					else if (pick < 96)
						cnt = 7'($urandom_range(33, 64));
					else
						cnt = 7'($urandom_range(65, 127));
					send_item(cba_pkg::OP_ALLOC, cnt, 6'($urandom), 1'($urandom), 1'b0, none);
					sent++;
				end else if (pick < 55) begin
					// release a stretch of neighboring blocks
					base = $urandom_range(0, cba_pkg::BLOCKS - 1);
					span = $urandom_range(1, 12);
					for (int k = 0; k < span && base + k < cba_pkg::BLOCKS; k++) begin
						send_item(cba_pkg::OP_SET, 7'($urandom), 6'(base + k), 1'b0, 1'b0,
							none);
						sent++;
					end
				end else begin
					send_item(cba_pkg::OP_SET, 7'($urandom),
						6'($urandom_range(0, cba_pkg::BLOCKS - 1)),
						1'($urandom_range(0, 99) < 25), 1'b0, none);
					sent++;
				end
			end
		end

		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
